// ----- src/assert_macros.svh -----
// Assertion macros shared by the address table RTL.
// Included by any module that carries concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MAW_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
`define MAW_NEVER(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
        else $error("forbidden condition seen");
`else
`define MAW_ASSERT(lbl, clk, rstn, prop)
`define MAW_NEVER(lbl, clk, rstn, prop)
`endif
`endif

// ----- src/maw_pkg.sv -----
// Shared types and codes for the meter address whitelist.
// Depends on nothing; every other file of the block but assert_macros.svh imports it.
`default_nettype none

package maw_pkg;

    localparam int TABLE_SLOTS_DEF = 32;

    localparam int REQ_W = 2;
    localparam int MFR_W = 16;
    localparam int ID_W  = 32;
    localparam int IDX_W = 5;
    localparam int STS_W = 2;
    localparam int CNT_W = 6;
    localparam int WORD_W = MFR_W + ID_W;

    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd3;

    localparam logic [STS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STS_W-1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [STS_W-1:0] status;
        logic             found;
        logic [CNT_W-1:0] entry_count;
        logic [MFR_W-1:0] read_manufacturer;
        logic [ID_W-1:0]  read_meter_id;
    } res_t;

endpackage

`default_nettype wire

// ----- src/maw_if.sv -----
// Valid/ready channel interfaces for requests and results of the whitelist.
// Depends on maw_pkg for the field widths.
`default_nettype none

interface maw_req_if;
    import maw_pkg::*;
    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] req_type;
    logic [MFR_W-1:0] manufacturer;
    logic [ID_W-1:0]  meter_id;
    logic [IDX_W-1:0] entry_index;

    modport source (output valid, output req_type, output manufacturer,
                    output meter_id, output entry_index, input ready);
    modport sink   (input valid, input req_type, input manufacturer,
                    input meter_id, input entry_index, output ready);
endinterface

interface maw_res_if;
    import maw_pkg::*;
    logic             valid;
    logic             ready;
    logic [STS_W-1:0] status;
    logic             found;
    logic [CNT_W-1:0] entry_count;
    logic [MFR_W-1:0] read_manufacturer;
    logic [ID_W-1:0]  read_meter_id;

    modport source (output valid, output status, output found, output entry_count,
                    output read_manufacturer, output read_meter_id, input ready);
    modport sink   (input valid, input status, input found, input entry_count,
                    input read_manufacturer, input read_meter_id, output ready);
endinterface

`default_nettype wire

// ----- src/maw_table_ram.sv -----
// Slot memory: one write port and one read port with registered read data.
// Depends on maw_pkg for the word width.
`default_nettype none

module maw_table_ram #(
    parameter int DEPTH = maw_pkg::TABLE_SLOTS_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [AW-1:0]             waddr,
    input  wire logic [maw_pkg::WORD_W-1:0] wdata,
    input  wire logic                      re,
    input  wire logic [AW-1:0]             raddr,
    output logic      [maw_pkg::WORD_W-1:0] rdata_reg
);
    import maw_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];

    // Each slot holds the manufacturer code above the identifier.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- src/maw_ctrl.sv -----
// Request sequencer: scans the slot memory, applies add/remove, builds results.
// Depends on maw_pkg, the channel interfaces and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module maw_ctrl #(
    parameter int TABLE_SLOTS = maw_pkg::TABLE_SLOTS_DEF,
    localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    maw_req_if.sink                         req,
    maw_res_if.source                       res,
    output logic                            mem_we,
    output logic      [AW-1:0]              mem_waddr,
    output logic      [maw_pkg::WORD_W-1:0] mem_wdata,
    output logic                            mem_re,
    output logic      [AW-1:0]              mem_raddr,
    input  wire logic [maw_pkg::WORD_W-1:0] mem_rdata
);
    import maw_pkg::*;

    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam int IW = 9;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_ACT    = 3'd2;
    localparam logic [2:0] S_MOVE   = 3'd3;
    localparam logic [2:0] S_IDXRD  = 3'd4;
    localparam logic [2:0] S_IDXCAP = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [REQ_W-1:0]  type_reg, type_next;
    logic [MFR_W-1:0]  mfr_reg, mfr_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CW-1:0]     issue_reg, issue_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [AW-1:0]     pend_idx_reg, pend_idx_next;
    logic              hit_reg, hit_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic [CW-1:0]     count_reg, count_next;
    res_t              rslt_reg, rslt_next;
    logic              out_valid_reg, out_valid_next;
    res_t              out_reg, out_next;

    logic [WORD_W-1:0] key;
    logic              hit_now;
    logic [CW-1:0]     last;
    logic [IW-1:0]     idx_w;
    logic [IW-1:0]     cnt_w;
    logic              count_step_ok;

    assign key     = {mfr_reg, id_reg};
    assign hit_now = pend_valid_reg && (mem_rdata == key);
    assign last    = count_reg - CW'(1);
    assign idx_w   = IW'(idx_reg);
    assign cnt_w   = IW'(count_reg);

    // The count moves by at most one per cycle.
    assign count_step_ok = (count_next == count_reg) || (count_next == count_reg + CW'(1)) ||
                           (count_next + CW'(1) == count_reg);

    assign req.ready             = (state_reg == S_IDLE);
    assign res.valid             = out_valid_reg;
    assign res.status            = out_reg.status;
    assign res.found             = out_reg.found;
    assign res.entry_count       = out_reg.entry_count;
    assign res.read_manufacturer = out_reg.read_manufacturer;
    assign res.read_meter_id     = out_reg.read_meter_id;

    always_comb
    begin
        state_next     = state_reg;
        type_next      = type_reg;
        mfr_next       = mfr_reg;
        id_next        = id_reg;
        idx_next       = idx_reg;
        issue_next     = issue_reg;
        hit_next       = hit_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        rslt_next      = rslt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        mem_we         = 1'b0;
        mem_waddr      = count_reg[AW-1:0];
        mem_wdata      = key;
        mem_re         = 1'b0;
        mem_raddr      = issue_reg[AW-1:0];

        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    type_next  = req.req_type;
                    mfr_next   = req.manufacturer;
                    id_next    = req.meter_id;
                    idx_next   = req.entry_index;
                    issue_next = '0;
                    hit_next   = 1'b0;
                    state_next = (req.req_type == REQ_READ) ? S_IDXRD : S_SCAN;
                end
            end
            S_SCAN:
            begin
                // One slot read is issued per cycle while the previous one is compared.
                if (hit_now)
                begin
                    hit_next   = 1'b1;
                    pos_next   = pend_idx_reg;
                    state_next = S_ACT;
                end
                else if (issue_reg >= count_reg)
                begin
                    state_next = S_ACT;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = issue_reg[AW-1:0];
                    issue_next = issue_reg + CW'(1);
                end
            end
            S_ACT:
            begin
                rslt_next       = '0;
                rslt_next.found = hit_reg;
                state_next      = S_DONE;
                case (type_reg)
                    REQ_ADD:
                    begin
                        if (!hit_reg)
                        begin
                            if (count_reg >= CW'(TABLE_SLOTS))
                            begin
                                rslt_next.status = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[AW-1:0];
                                count_next = count_reg + CW'(1);
                            end
                        end
                    end
                    REQ_REMOVE:
                    begin
                        if (!hit_reg)
                        begin
                            rslt_next.status = ST_NOT_FOUND;
                        end
                        else
                        begin
                            count_next = last;
                            // The last entry fills the hole unless it is the hole.
                            if (pos_reg != last[AW-1:0])
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = last[AW-1:0];
                                state_next = S_MOVE;
                            end
                        end
                    end
                    default:
                    begin
                        if (!hit_reg)
                        begin
                            rslt_next.status = ST_NOT_FOUND;
                        end
                    end
                endcase
            end
            S_MOVE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = mem_rdata;
                state_next = S_DONE;
            end
            S_IDXRD:
            begin
                rslt_next = '0;
                if (idx_w < cnt_w)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = idx_w[AW-1:0];
                    state_next = S_IDXCAP;
                end
                else
                begin
                    rslt_next.status = ST_NOT_FOUND;
                    state_next       = S_DONE;
                end
            end
            S_IDXCAP:
            begin
                rslt_next                   = '0;
                rslt_next.found             = 1'b1;
                rslt_next.read_manufacturer = mem_rdata[WORD_W-1:ID_W];
                rslt_next.read_meter_id     = mem_rdata[ID_W-1:0];
                state_next                  = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_next             = rslt_reg;
                    out_next.entry_count = cnt_w[CNT_W-1:0];
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        pend_valid_next = mem_re && (state_reg == S_SCAN);
        pend_idx_next   = mem_raddr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            hit_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            hit_reg        <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg     <= type_next;
        mfr_reg      <= mfr_next;
        id_reg       <= id_next;
        idx_reg      <= idx_next;
        issue_reg    <= issue_next;
        pend_idx_reg <= pend_idx_next;
        pos_reg      <= pos_next;
        rslt_reg     <= rslt_next;
        out_reg      <= out_next;
    end

    `MAW_ASSERT(a_count_bound, clk, rst_n, count_reg <= CW'(TABLE_SLOTS))
    `MAW_ASSERT(a_count_step, clk, rst_n, count_step_ok)
    `MAW_ASSERT(a_write_in_range, clk, rst_n, mem_we |-> (IW'(mem_waddr) <= IW'(count_reg)))
    `MAW_NEVER(a_rd_wr_overlap, clk, rst_n, mem_we && mem_re)

endmodule

`default_nettype wire

// ----- src/meter_address_whitelist.sv -----
// Top level of the meter address whitelist: request sequencer plus slot memory.
// Depends on maw_pkg, maw_if, maw_table_ram and maw_ctrl.
`default_nettype none

//  channel | role   | payload
//  --------+--------+---------------------------------------------------------
//  req     | sink   | req_type, manufacturer, meter_id, entry_index
//  res     | source | status, found, entry_count, read_manufacturer, read_meter_id
//
// One item is handled at a time. A lookup, add or remove scans the stored slots
// through the memory read port, one slot per cycle, and stops at the first match.
// A remove that hits moves the last entry into the freed slot, unless the match was
// the last entry. A read by index reads its slot only when the index is below the
// count and otherwise reports not found. Reset clears the entry count and the
// control state; slot contents are never cleared because slots at or past the
// count are never read.
// A result waits in an output register while the next item is accepted; the
// block only stalls when a new result is ready and that register is still full.

module meter_address_whitelist #(
    parameter int TABLE_SLOTS = maw_pkg::TABLE_SLOTS_DEF
) (
    input wire logic  clk,
    input wire logic  rst_n,
    maw_req_if.sink   req,
    maw_res_if.source res
);
    import maw_pkg::*;

    localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

    // Memory port between the sequencer and the slot array.
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [WORD_W-1:0] mem_rdata;

    // The sequencer owns the count and all decisions; the memory just stores slots.
    maw_ctrl #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    maw_table_ram #(
        .DEPTH (TABLE_SLOTS)
    ) u_ram (
        .clk       (clk),
        .we        (mem_we),
        .waddr     (mem_waddr),
        .wdata     (mem_wdata),
        .re        (mem_re),
        .raddr     (mem_raddr),
        .rdata_reg (mem_rdata)
    );

endmodule

`default_nettype wire

// ----- test/meter_address_whitelist_tb.sv -----
// Self-checking testbench for the meter address whitelist.
// Depends on maw_pkg, the maw_req_if/maw_res_if interfaces and meter_address_whitelist.
`default_nettype none

module meter_address_whitelist_tb;
    import maw_pkg::*;

    // The table depth under test and the number of random items after the directed part.
    localparam int TABLE_DEPTH  = TABLE_SLOTS_DEF;
    localparam int RANDOM_ITEMS = 400;
    // Items at the end of the run that go through with no idling on either side.
    localparam int QUIET_TAIL   = 60;
    // Size of the address pool that the random part draws from.
    localparam int POOL_SIZE    = 48;
    // A quiet tail after the last expected result has come back, to catch stray items.
    localparam int DRAIN_CYCLES = 50;
    // Slowest correct run is around 425 items; this limit is far above what it needs.
    localparam int CYCLE_LIMIT  = 200000;

    // One request item as it travels on the request channel.
    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [MFR_W-1:0] manufacturer;
        logic [ID_W-1:0]  meter_id;
        logic [IDX_W-1:0] entry_index;
    } whitelist_req_t;

    // A row of the directed part. Where has_typed is set, the result is written
    // out by hand; otherwise the shadow table supplies it.
    typedef struct {
        whitelist_req_t req;
        bit             has_typed;
        res_t           typed_res;
    } directed_row_t;

    // Mix of requests used in one stretch of the random part.
    typedef enum int {EP_FILL, EP_DRAIN, EP_MIXED} episode_t;

    logic clk;
    logic rst_n;

    maw_req_if req_ch();
    maw_res_if res_ch();

    meter_address_whitelist #(
        .TABLE_SLOTS(TABLE_DEPTH)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch.sink),
        .res  (res_ch.source)
    );

    // Shadow copy of the address table. Only slots below shadow_count are meaningful.
    logic [MFR_W-1:0] shadow_mfr [TABLE_DEPTH];
    logic [ID_W-1:0]  shadow_id  [TABLE_DEPTH];
    int               shadow_count;

    // Results that the block still owes, oldest first.
    res_t pending_results[$];

    directed_row_t directed_rows[$];

    // Address pool: most random requests pick from it so that hits, duplicates,
    // removes that succeed and a full table all come up often.
    logic [MFR_W-1:0] pool_mfr [POOL_SIZE];
    logic [ID_W-1:0]  pool_id  [POOL_SIZE];

    int  error_count;
    int  cycle_count;
    bit  idle_on;
    int  stall_left;
    res_t got_res;
    res_t want_res;

    // Clock with a period of 10 time units.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Works out the result of one request against the shadow table and applies the
    // request to it. A matching address needs both the manufacturer and the
    // identifier to be equal. The duplicate check comes before the full check, so a
    // duplicate add on a full table still reports ok.
    function automatic res_t predict_table_result(input whitelist_req_t r);
        res_t o;
        int   hit;
        int   last;
        o = '0;
        o.status = ST_OK;
        hit = -1;
        for (int i = 0; i < shadow_count; i++)
        begin
            if (hit < 0 && shadow_mfr[i] == r.manufacturer && shadow_id[i] == r.meter_id)
                hit = i;
        end
        case (r.req_type)
            REQ_LOOKUP:
            begin
                if (hit >= 0)
                    o.found = 1'b1;
                else
                    o.status = ST_NOT_FOUND;
            end
            REQ_ADD:
            begin
                if (hit >= 0)
                    o.found = 1'b1;
                else if (shadow_count >= TABLE_DEPTH)
                    o.status = ST_FULL;
                else
                begin
                    shadow_mfr[shadow_count] = r.manufacturer;
                    shadow_id[shadow_count]  = r.meter_id;
                    shadow_count++;
                end
            end
            REQ_REMOVE:
            begin
                // The last valid entry moves into the freed slot.
                if (hit >= 0)
                begin
                    o.found = 1'b1;
                    last = shadow_count - 1;
                    shadow_mfr[hit] = shadow_mfr[last];
                    shadow_id[hit]  = shadow_id[last];
                    shadow_count = last;
                end
                else
                    o.status = ST_NOT_FOUND;
            end
            default:
            begin
                // Read by index: only slots below the count hold an entry.
                if (int'(r.entry_index) < shadow_count)
                begin
                    o.found = 1'b1;
                    o.read_manufacturer = shadow_mfr[r.entry_index];
                    o.read_meter_id     = shadow_id[r.entry_index];
                end
                else
                    o.status = ST_NOT_FOUND;
            end
        endcase
        o.entry_count = CNT_W'(shadow_count);
        return o;
    endfunction

    // Appends one row to the directed part.
    task automatic add_row(input logic [REQ_W-1:0] rt, input logic [MFR_W-1:0] m,
                           input logic [ID_W-1:0] id, input logic [IDX_W-1:0] ix,
                           input bit typed, input logic [STS_W-1:0] st, input logic fnd,
                           input logic [CNT_W-1:0] cnt, input logic [MFR_W-1:0] rm,
                           input logic [ID_W-1:0] rid);
        directed_row_t row;
        row.req       = '{req_type: rt, manufacturer: m, meter_id: id, entry_index: ix};
        row.has_typed = typed;
        row.typed_res = '{status: st, found: fnd, entry_count: cnt,
                          read_manufacturer: rm, read_meter_id: rid};
        directed_rows.push_back(row);
    endtask

    // Presents one item on the request channel, with an optional idle burst first,
    // and waits for the handshake. On acceptance the expected result is queued.
    // Called at a point where the previous item, if any, has just been accepted, so
    // valid stays high into the next item unless an idle burst is chosen.
    task automatic send_request(input whitelist_req_t r, input bit typed, input res_t typed_res);
        res_t predicted;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= r.req_type;
        req_ch.manufacturer <= r.manufacturer;
        req_ch.meter_id     <= r.meter_id;
        req_ch.entry_index  <= r.entry_index;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = predict_table_result(r);
        if (typed)
            pending_results.push_back(typed_res);
        else
            pending_results.push_back(predicted);
    endtask

    // Picks an address for a random request: mostly from the pool, sometimes noise.
    task automatic pick_address(output logic [MFR_W-1:0] m, output logic [ID_W-1:0] id);
        int p;
        if ($urandom_range(0, 99) < 85)
        begin
            p  = $urandom_range(0, POOL_SIZE - 1);
            m  = pool_mfr[p];
            id = pool_id[p];
        end
        else
        begin
            m  = MFR_W'($urandom);
            id = $urandom;
        end
    endtask

    // Result side: the ready line idles in random bursts while idling is on,
    // and stays high otherwise.
    initial
    begin
        res_ch.ready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
                res_ch.ready <= 1'b0;
            else if (stall_left > 0)
            begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                res_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // Every accepted result is compared field by field with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got_res = '{status: res_ch.status, found: res_ch.found,
                        entry_count: res_ch.entry_count,
                        read_manufacturer: res_ch.read_manufacturer,
                        read_meter_id: res_ch.read_meter_id};
            if (pending_results.size() == 0)
            begin
                $display("%0t: result item with nothing expected, actual %h", $time, got_res);
                error_count++;
            end
            else
            begin
                want_res = pending_results.pop_front();
                if (got_res.status !== want_res.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want_res.status, got_res.status);
                    error_count++;
                end
                if (got_res.found !== want_res.found)
                begin
                    $display("%0t: found expected %0d actual %0d",
                             $time, want_res.found, got_res.found);
                    error_count++;
                end
                if (got_res.entry_count !== want_res.entry_count)
                begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, want_res.entry_count, got_res.entry_count);
                    error_count++;
                end
                if (got_res.read_manufacturer !== want_res.read_manufacturer)
                begin
                    $display("%0t: read_manufacturer expected %h actual %h",
                             $time, want_res.read_manufacturer, got_res.read_manufacturer);
                    error_count++;
                end
                if (got_res.read_meter_id !== want_res.read_meter_id)
                begin
                    $display("%0t: read_meter_id expected %h actual %h",
                             $time, want_res.read_meter_id, got_res.read_meter_id);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Main sequence: reset, directed rows, random episodes, then drain and report.
    initial
    begin
        whitelist_req_t   r;
        episode_t         kind;
        int               rand_sent;
        int               len;
        int               pick;
        bit               first_episode;
        logic [MFR_W-1:0] mfr_choice [4];

        // All block inputs are known from time zero.
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = REQ_LOOKUP;
        req_ch.manufacturer = '0;
        req_ch.meter_id     = '0;
        req_ch.entry_index  = '0;
        error_count  = 0;
        cycle_count  = 0;
        idle_on      = 1'b1;
        shadow_count = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            shadow_mfr[i] = '0;
            shadow_id[i]  = '0;
        end

        // The pool uses few manufacturer codes, the extremes among them, so that
        // partial matches are common. Entries 32..39 differ from an earlier entry in
        // one identifier bit; entries 40..47 share an identifier with a different
        // manufacturer code. Neither kind may match the original.
        mfr_choice[0] = '0;
        mfr_choice[1] = '1;
        mfr_choice[2] = MFR_W'($urandom);
        mfr_choice[3] = MFR_W'($urandom);
        for (int i = 0; i < 32; i++)
        begin
            pool_mfr[i] = mfr_choice[$urandom_range(0, 3)];
            pool_id[i]  = $urandom;
        end
        for (int i = 32; i < 40; i++)
        begin
            pool_mfr[i] = pool_mfr[i - 32];
            pool_id[i]  = pool_id[i - 32] ^ (32'd1 << $urandom_range(0, ID_W - 1));
        end
        for (int i = 40; i < POOL_SIZE; i++)
        begin
            pool_mfr[i] = pool_mfr[i - 40] ^ (16'd1 << $urandom_range(0, MFR_W - 1));
            pool_id[i]  = pool_id[i - 40];
        end

        // Directed rows. The hand-written results follow from an empty table after
        // reset; the rest come from the shadow table.
        // Lookup, read and remove on an empty table all miss.
        add_row(REQ_LOOKUP, '0, '0, '0, 1'b1, ST_NOT_FOUND, 1'b0, 6'd0, '0, '0);
        add_row(REQ_READ, '0, '0, '0, 1'b1, ST_NOT_FOUND, 1'b0, 6'd0, '0, '0);
        add_row(REQ_REMOVE, '1, '1, '1, 1'b1, ST_NOT_FOUND, 1'b0, 6'd0, '0, '0);
        // Add of the all-ones address, then the same address again as a duplicate.
        add_row(REQ_ADD, '1, '1, '0, 1'b1, ST_OK, 1'b0, 6'd1, '0, '0);
        add_row(REQ_ADD, '1, '1, '0, 1'b1, ST_OK, 1'b1, 6'd1, '0, '0);
        add_row(REQ_LOOKUP, '1, '1, '0, 1'b1, ST_OK, 1'b1, 6'd1, '0, '0);
        add_row(REQ_READ, '0, '0, 5'd0, 1'b1, ST_OK, 1'b1, 6'd1, '1, '1);
        // Read at the highest index, far past the count.
        add_row(REQ_READ, '1, '1, '1, 1'b1, ST_NOT_FOUND, 1'b0, 6'd1, '0, '0);
        add_row(REQ_ADD, '0, '0, '1, 1'b1, ST_OK, 1'b0, 6'd2, '0, '0);
        // Half matches: one part equal, the other not.
        add_row(REQ_LOOKUP, '1, '0, '0, 1'b0, ST_OK, 1'b0, '0, '0, '0);
        add_row(REQ_LOOKUP, '0, '1, '0, 1'b0, ST_OK, 1'b0, '0, '0, '0);
        add_row(REQ_ADD, 16'h1234, 32'hA5A5_A5A5, '0, 1'b0, ST_OK, 1'b0, '0, '0, '0);
        add_row(REQ_ADD, 16'h8000, 32'h0000_0001, '0, 1'b0, ST_OK, 1'b0, '0, '0, '0);
        add_row(REQ_READ, '0, '0, 5'd1, 1'b0, ST_OK, 1'b0, '0, '0, '0);
        // Removing the first slot moves the last entry into it.
        add_row(REQ_REMOVE, '1, '1, '0, 1'b0, ST_OK, 1'b0, '0, '0, '0);
        add_row(REQ_READ, '0, '0, 5'd0, 1'b0, ST_OK, 1'b0, '0, '0, '0);
        add_row(REQ_REMOVE, 16'h8000, 32'h0000_0001, '0, 1'b0, ST_OK, 1'b0, '0, '0, '0);
        // A second remove of the same address misses.
        add_row(REQ_REMOVE, 16'h8000, 32'h0000_0001, '0, 1'b0, ST_OK, 1'b0, '0, '0, '0);
        add_row(REQ_READ, '0, '0, 5'd2, 1'b0, ST_OK, 1'b0, '0, '0, '0);
        add_row(REQ_READ, '0, '0, 5'd1, 1'b0, ST_OK, 1'b0, '0, '0, '0);
        // The index field is ignored on a lookup.
        add_row(REQ_LOOKUP, 16'h1234, 32'hA5A5_A5A5, '1, 1'b0, ST_OK, 1'b0, '0, '0, '0);
        // Removing the last slot needs no move; the table ends empty.
        add_row(REQ_REMOVE, '0, '0, '0, 1'b0, ST_OK, 1'b0, '0, '0, '0);
        add_row(REQ_REMOVE, 16'h1234, 32'hA5A5_A5A5, '0, 1'b0, ST_OK, 1'b0, '0, '0, '0);
        add_row(REQ_READ, '1, '1, 5'd0, 1'b1, ST_NOT_FOUND, 1'b0, 6'd0, '0, '0);

        // Reset is held low, then released at a falling edge.
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].has_typed,
                         directed_rows[i].typed_res);

        // Random part in episodes. The first one fills the table so that full and
        // duplicate-on-full adds come early; later episodes fill, drain or mix.
        rand_sent = 0;
        first_episode = 1'b1;
        while (rand_sent < RANDOM_ITEMS)
        begin
            kind = first_episode ? EP_FILL : episode_t'($urandom_range(0, 2));
            first_episode = 1'b0;
            len = $urandom_range(30, 70);
            // Some episodes run with no idling at all.
            idle_on = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < len && rand_sent < RANDOM_ITEMS; k++)
            begin
                if (rand_sent >= RANDOM_ITEMS - QUIET_TAIL)
                    idle_on = 1'b0;
                pick = $urandom_range(0, 99);
                case (kind)
                    EP_FILL:
                        r.req_type = (pick < 75) ? REQ_ADD : (pick < 85) ? REQ_LOOKUP :
                                     (pick < 95) ? REQ_READ : REQ_REMOVE;
                    EP_DRAIN:
                        r.req_type = (pick < 60) ? REQ_REMOVE : (pick < 75) ? REQ_ADD :
                                     (pick < 88) ? REQ_LOOKUP : REQ_READ;
                    default:
                        r.req_type = REQ_W'(pick % 4);
                endcase
                pick_address(r.manufacturer, r.meter_id);
                // Reads mostly aim at valid slots; the rest land anywhere.
                if (r.req_type == REQ_READ && shadow_count > 0 && $urandom_range(0, 9) < 7)
                    r.entry_index = IDX_W'($urandom_range(0, shadow_count - 1));
                else
                    r.entry_index = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
                send_request(r, 1'b0, '0);
                rand_sent++;
            end
        end

        @(negedge clk);
        req_ch.valid <= 1'b0;

        // Wait for every owed result, then a quiet tail to catch stray items.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
